### design/totf_pkg.sv
`default_nettype none

package totf_pkg;

    // store size and coordinate precision
    localparam int MAX_TILES  = 64;
    localparam int COORD_BITS = 16;

    // fixed field widths of the channels
    localparam int VERTEX_W      = 16;
    localparam int SLOT_W        = 6;
    localparam int COUNT_FIELD_W = 7;

    // derived widths
    localparam int IDX_W   = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int COUNT_W = $clog2(MAX_TILES + 1);
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    // opcodes
    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;

    // one triangle: three vertices
    typedef struct packed {
        coord_t [2:0] x;
        coord_t [2:0] y;
    } tile_t;

    // status of the point test pipeline
    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } test_status_t;

endpackage

`default_nettype wire

### design/totf_ifs.sv
`default_nettype none

// triangle offer / clear channel
interface totf_tri_if;
    import totf_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic [VERTEX_W-1:0] vertex_a_x;
    logic [VERTEX_W-1:0] vertex_a_y;
    logic [VERTEX_W-1:0] vertex_b_x;
    logic [VERTEX_W-1:0] vertex_b_y;
    logic [VERTEX_W-1:0] vertex_c_x;
    logic [VERTEX_W-1:0] vertex_c_y;

    modport source (
        output valid, opcode, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y,
        input  ready
    );
    modport sink (
        input  valid, opcode, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y,
        output ready
    );
endinterface

// filter result channel
interface totf_res_if;
    import totf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic                     overlaps;
    logic                     store_full;
    logic [SLOT_W-1:0]        slot;
    logic [COUNT_FIELD_W-1:0] count_now;

    modport source (
        output valid, accepted, overlaps, store_full, slot, count_now,
        input  ready
    );
    modport sink (
        input  valid, accepted, overlaps, store_full, slot, count_now,
        output ready
    );
endinterface

`default_nettype wire

### design/totf_cell.sv
`default_nettype none

module totf_cell (
    input  wire logic          clk,
    input  wire logic          shift_en,
    input  wire totf_pkg::tile_t tile_in,
    input  wire logic          load_en,
    input  wire totf_pkg::tile_t load_tile,
    output totf_pkg::tile_t    tile_out
);
    import totf_pkg::*;

    tile_t tile_reg;
    tile_t tile_next;

    // load a new tile, or take the neighbor's tile while the ring turns
    always_comb
    begin
        tile_next = tile_reg;
        if (load_en)
        begin
            tile_next = load_tile;
        end
        else if (shift_en)
        begin
            tile_next = tile_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tile_reg <= tile_next;
    end

    assign tile_out = tile_reg;

endmodule

`default_nettype wire

### design/totf_test.sv
`default_nettype none

module totf_test (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            valid_in,
    input  wire totf_pkg::tile_t tile,
    input  wire totf_pkg::tile_t cand,
    output totf_pkg::test_status_t status
);
    import totf_pkg::*;

    // edge e runs from vertex EDGE_A[e] to EDGE_B[e]; the opposite vertex
    // sees the tile orientation flipped on the middle edge
    localparam int   EDGE_A [3] = '{1, 0, 0};
    localparam int   EDGE_B [3] = '{2, 2, 1};
    localparam logic EDGE_FLIP [3] = '{1'b0, 1'b1, 1'b0};

    logic signed [DIFF_W-1:0] ex_reg [3];
    logic signed [DIFF_W-1:0] ey_reg [3];
    logic signed [DIFF_W-1:0] dx_reg [3][3];
    logic signed [DIFF_W-1:0] dy_reg [3][3];
    logic signed [PROD_W-1:0] m1_reg [3][3];
    logic signed [PROD_W-1:0] m2_reg [3][3];
    logic signed [PROD_W-1:0] d1_reg;
    logic signed [PROD_W-1:0] d2_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic                     hit_reg;
    logic                     hit_next;

    // stage 1: edge vectors and point offsets
    always_ff @(posedge clk)
    begin
        for (int e = 0; e < 3; e++)
        begin
            ex_reg[e] <= $signed({1'b0, tile.x[EDGE_B[e]]})
                       - $signed({1'b0, tile.x[EDGE_A[e]]});
            ey_reg[e] <= $signed({1'b0, tile.y[EDGE_B[e]]})
                       - $signed({1'b0, tile.y[EDGE_A[e]]});
            for (int v = 0; v < 3; v++)
            begin
                dx_reg[v][e] <= $signed({1'b0, cand.x[v]})
                              - $signed({1'b0, tile.x[EDGE_A[e]]});
                dy_reg[v][e] <= $signed({1'b0, cand.y[v]})
                              - $signed({1'b0, tile.y[EDGE_A[e]]});
            end
        end
    end

    // stage 2: cross product terms and the tile orientation terms
    always_ff @(posedge clk)
    begin
        for (int e = 0; e < 3; e++)
        begin
            for (int v = 0; v < 3; v++)
            begin
                m1_reg[v][e] <= ex_reg[e] * dy_reg[v][e];
                m2_reg[v][e] <= ey_reg[e] * dx_reg[v][e];
            end
        end
        d1_reg <= ex_reg[2] * ey_reg[1];
        d2_reg <= ey_reg[2] * ex_reg[1];
    end

    // stage 3: signs, same-side decision per edge, any vertex inside
    always_comb
    begin
        logic signed [CROSS_W-1:0] cp;
        logic signed [CROSS_W-1:0] dv;
        logic                      d_zero;
        logic                      d_neg;
        logic                      sp_zero;
        logic                      sp_neg;
        logic                      sr_neg;
        logic                      in_tile;
        dv       = CROSS_W'(d1_reg) - CROSS_W'(d2_reg);
        d_zero   = (dv == '0);
        d_neg    = dv[CROSS_W-1];
        hit_next = 1'b0;
        for (int v = 0; v < 3; v++)
        begin
            in_tile = 1'b1;
            for (int e = 0; e < 3; e++)
            begin
                cp      = CROSS_W'(m1_reg[v][e]) - CROSS_W'(m2_reg[v][e]);
                sp_zero = (cp == '0);
                sp_neg  = cp[CROSS_W-1];
                sr_neg  = EDGE_FLIP[e] ? !d_neg : d_neg;
                if (!(sp_zero || d_zero || (sp_neg == sr_neg)))
                begin
                    in_tile = 1'b0;
                end
            end
            if (in_tile)
            begin
                hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    // valid flags along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign status.busy      = v1_reg | v2_reg | v3_reg;
    assign status.hit_valid = v3_reg;
    assign status.hit       = hit_reg;

endmodule

`default_nettype wire

### design/triangle_overlap_tile_filter.sv
// Triangle overlap tile filter.
// Input channel "triangles": opcode plus three vertices. Opcode clear empties
// the tile store; opcode offer tests the triangle against every stored tile
// and appends it if there is room and no vertex lies inside or on a stored tile.
// Output channel "results": one transfer per input transfer, in order.
// Stored tiles sit in a ring of MAX_TILES cells. For an offer the ring makes
// one full turn, one tile per cycle past a three-stage test pipeline; a clear
// skips the scan. The next input is taken the cycle after the result is
// registered, so the filter works on one item at a time.
// The result register lets a new item be accepted while a result waits; if
// the receiver stalls, the item after that holds at its final step until
// the result register frees up.
// Reset empties the store (tile count zero) and drops any pending result;
// tile contents are not cleared, only entries below the count are read.
`default_nettype none

module triangle_overlap_tile_filter (
    input  wire logic clk,
    input  wire logic rst_n,
    totf_tri_if.sink  triangles,
    totf_res_if.source results
);
    import totf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [IDX_W-1:0]   scan_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;
    logic               clear_reg;
    logic               overlap_reg;
    tile_t              cand_reg;
    tile_t              cand_in;
    tile_t              tiles [MAX_TILES];
    test_status_t       status;
    logic               in_fire;
    logic               finish_go;
    logic               append;
    logic               test_valid;
    logic               shift_en;
    logic [31:0]        total_ext;

    logic               out_valid_reg;
    logic               out_accepted_reg;
    logic               out_overlaps_reg;
    logic               out_full_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [COUNT_FIELD_W-1:0] out_count_reg;

    // input transfer and candidate capture
    assign triangles.ready = (state_reg == ST_IDLE);
    assign in_fire         = triangles.valid && triangles.ready;

    assign cand_in.x[0] = COORD_BITS'(triangles.vertex_a_x);
    assign cand_in.y[0] = COORD_BITS'(triangles.vertex_a_y);
    assign cand_in.x[1] = COORD_BITS'(triangles.vertex_b_x);
    assign cand_in.y[1] = COORD_BITS'(triangles.vertex_b_y);
    assign cand_in.x[2] = COORD_BITS'(triangles.vertex_c_x);
    assign cand_in.y[2] = COORD_BITS'(triangles.vertex_c_y);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cand_reg  <= cand_in;
            clear_reg <= (triangles.opcode == OP_CLEAR);
        end
    end

    // ring control and test feed
    assign shift_en   = (state_reg == ST_SCAN);
    assign test_valid = shift_en && (COUNT_W'(scan_reg) < total_reg);

    // tile ring: cell i takes its tile from cell i+1, the last from cell 0
    for (genvar i = 0; i < MAX_TILES; i++)
    begin : g_cell
        totf_cell u_cell (
            .clk       (clk),
            .shift_en  (shift_en),
            .tile_in   (tiles[(i + 1) % MAX_TILES]),
            .load_en   (finish_go && append && (total_reg == COUNT_W'(i))),
            .load_tile (cand_reg),
            .tile_out  (tiles[i])
        );
    end

    totf_test u_test (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (test_valid),
        .tile     (tiles[0]),
        .cand     (cand_reg),
        .status   (status)
    );

    // final step: decide and commit once the result register is free
    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || results.ready);
    assign append    = !clear_reg && !overlap_reg && (total_reg != COUNT_W'(MAX_TILES));

    always_comb
    begin
        total_next = total_reg;
        if (finish_go)
        begin
            if (clear_reg)
            begin
                total_next = '0;
            end
            else if (append)
            begin
                total_next = total_reg + COUNT_W'(1);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (triangles.opcode == OP_CLEAR) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == IDX_W'(MAX_TILES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            scan_reg    <= '0;
            total_reg   <= '0;
            overlap_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            if (in_fire)
            begin
                scan_reg <= '0;
            end
            else if (shift_en)
            begin
                scan_reg <= scan_reg + IDX_W'(1);
            end
            // accumulate hits over the whole scan
            if (in_fire)
            begin
                overlap_reg <= 1'b0;
            end
            else if (status.hit_valid && status.hit)
            begin
                overlap_reg <= 1'b1;
            end
        end
    end

    // result register
    assign total_ext = 32'(total_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            out_accepted_reg <= append;
            out_overlaps_reg <= !clear_reg && overlap_reg;
            out_full_reg     <= !clear_reg && !overlap_reg && !append;
            out_slot_reg     <= append ? total_ext[SLOT_W-1:0] : '0;
            out_count_reg    <= clear_reg ? '0 :
                                (append ? 7'(total_ext + 32'd1) : total_ext[COUNT_FIELD_W-1:0]);
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.accepted   = out_accepted_reg;
    assign results.overlaps   = out_overlaps_reg;
    assign results.store_full = out_full_reg;
    assign results.slot       = out_slot_reg;
    assign results.count_now  = out_count_reg;

`ifndef NO_ASSERTIONS
    // an accepted item always takes the filter out of the idle step
    assert property (@(posedge clk) disable iff (!rst_n)
        (triangles.valid && triangles.ready) |=> !triangles.ready)
    else $error("input taken twice in a row");

    // an appended triangle never reports overlap or a full store
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.accepted) |-> (!results.overlaps && !results.store_full))
    else $error("accepted result with conflicting flags");

    // test results only come back while a scan is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        status.hit_valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
    else $error("test result outside a scan");

    // tile count stays within the store and only grows by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg > $past(total_reg)) |-> (total_reg == $past(total_reg) + COUNT_W'(1)
            && total_reg <= COUNT_W'(MAX_TILES)))
    else $error("tile count out of step");
`endif

endmodule

`default_nettype wire
